### hdl/irpwd_pkg.sv
package irpwd_pkg;

    // Payload widths shared by the channel interfaces and the decoder.
    localparam int ACTION_W  = 2;
    localparam int TIME_W    = 16;
    localparam int DATA_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd6;

    // Register values after reset.
    localparam logic [CFG_W-1:0] HEADER_MIN_RST = 16'd124;
    localparam logic [CFG_W-1:0] SPACE_MIN_RST  = 16'd24;
    localparam logic [CFG_W-1:0] SPACE_MAX_RST  = 16'd44;
    localparam logic [CFG_W-1:0] BIT_MIN_RST    = 16'd24;
    localparam logic [CFG_W-1:0] BIT_MAX_RST    = 16'd77;
    localparam logic [CFG_W-1:0] ONE_THRESH_RST = 16'd50;
    localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd200;

    // Bit count at which the frame is treated as an overflow.
    localparam logic [COUNT_W-1:0] BITS_LIMIT = 8'hff;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_SPACE  = 5'b00100,
        PH_PULSE  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              expect_rising;
        logic              frame_ready;
        logic              frame_dropped;
        logic              read_valid;
        logic [DATA_W-1:0]  data_byte;
        logic [COUNT_W-1:0] bit_total;
        logic              last;
    } result_t;

endpackage

### hdl/irpwd_if.sv
interface irpwd_item_if
    import irpwd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TIME_W-1:0]   timestamp;

    modport source (output valid, output action, output timestamp, input ready);
    modport sink   (input valid, input action, input timestamp, output ready);
endinterface

interface irpwd_result_if
    import irpwd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               expect_rising;
    logic               frame_ready;
    logic               frame_dropped;
    logic               read_valid;
    logic [DATA_W-1:0]  data_byte;
    logic [COUNT_W-1:0] bit_total;
    logic               last;

    modport source (
        output valid, output expect_rising, output frame_ready, output frame_dropped,
        output read_valid, output data_byte, output bit_total, output last,
        input ready
    );
    modport sink (
        input valid, input expect_rising, input frame_ready, input frame_dropped,
        input read_valid, input data_byte, input bit_total, input last,
        output ready
    );
endinterface

interface irpwd_cfg_if
    import irpwd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/ir_pulse_width_decoder_unit.sv
// A transaction passes from the input register to the result register. It waits in the input
// register while a frame read runs or while the pending result has not been taken.
// One edge, tick or empty read per cycle while results are taken; a frame read of n bytes
// holds the result register until its n bytes are taken, at most one byte a cycle.
// Reset (rst_n, asynchronous, active low): decoder idle, registers at their defaults,
// frame store cleared, no result pending.
module ir_pulse_width_decoder_unit
    import irpwd_pkg::*;
#(
    parameter int STORE_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    irpwd_item_if.sink     item,
    irpwd_result_if.source result,
    irpwd_cfg_if.sink      cfg
);

    localparam int STORE_AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [5:0] STORE_CAP = 6'(STORE_BYTES);

    // Configuration registers.
    logic [CFG_W-1:0] header_min_reg, space_min_reg, space_max_reg;
    logic [CFG_W-1:0] bit_min_reg, bit_max_reg, one_thresh_reg, timeout_reg;

    // Input register.
    logic                s1_valid_reg;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [TIME_W-1:0]   s1_time_reg;

    // Decoder state.
    phase_t             phase_reg, phase_next;
    logic [TIME_W-1:0]  prev_reg, prev_next;
    logic [COUNT_W-1:0] bits_reg, bits_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic               armed_reg, armed_next;
    logic               want_rising_reg, want_rising_next;
    logic [DATA_W-1:0]  store_reg [STORE_BYTES];

    // Frame read sequencer and result register.
    logic                rd_active_reg, rd_active_next;
    logic [STORE_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [STORE_AW-1:0] rd_last_reg, rd_last_next;
    logic [COUNT_W-1:0]  rd_total_reg, rd_total_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                out_free;
    logic                s1_fire;
    logic                rd_fire;
    logic [TIME_W-1:0]   delta;
    logic [TIME_W-1:0]   deadline_new;
    logic [COUNT_W-1:0]  bits_inc;
    logic                dropped;
    logic                read_go;
    logic                store_we;
    logic                store_bit;
    logic [STORE_AW-1:0] wr_byte;
    logic [2:0]          wr_bit;
    logic                in_store;
    logic [5:0]          nbytes_raw;
    logic [5:0]          nbytes;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && !rd_active_reg && out_free;
    assign rd_fire    = rd_active_reg && out_free;
    assign item.ready = !s1_valid_reg || s1_fire;
    assign cfg.ready  = 1'b1;

    assign delta        = s1_time_reg - prev_reg;
    assign deadline_new = s1_time_reg + timeout_reg;
    assign bits_inc     = bits_reg + 8'd1;
    assign wr_byte      = STORE_AW'(bits_reg[7:3]);
    assign wr_bit       = bits_reg[2:0];
    assign in_store     = {1'b0, bits_reg[7:3]} < STORE_CAP;
    assign nbytes_raw   = {1'b0, bits_reg[7:3]} + {5'd0, |bits_reg[2:0]};
    assign nbytes       = (nbytes_raw > STORE_CAP) ? STORE_CAP : nbytes_raw;

    always_comb
    begin
        phase_next       = phase_reg;
        prev_next        = prev_reg;
        bits_next        = bits_reg;
        deadline_next    = deadline_reg;
        armed_next       = armed_reg;
        want_rising_next = want_rising_reg;
        dropped          = 1'b0;
        read_go          = 1'b0;
        store_we         = 1'b0;
        store_bit        = delta > one_thresh_reg;

        if (s1_fire)
        begin
            case (s1_action_reg)
                ACT_EDGE:
                begin
                    prev_next = s1_time_reg;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            want_rising_next = 1'b1;
                            phase_next       = PH_HEADER;
                        end
                        PH_HEADER:
                        begin
                            if (delta < header_min_reg)
                                dropped = 1'b1;
                            else
                            begin
                                deadline_next    = deadline_new;
                                armed_next       = 1'b1;
                                want_rising_next = 1'b0;
                                phase_next       = PH_SPACE;
                            end
                        end
                        PH_SPACE:
                        begin
                            deadline_next = deadline_new;
                            if (delta < space_min_reg || delta > space_max_reg)
                                dropped = 1'b1;
                            else
                            begin
                                want_rising_next = 1'b1;
                                phase_next       = PH_PULSE;
                            end
                        end
                        PH_PULSE:
                        begin
                            deadline_next = deadline_new;
                            if (delta < bit_min_reg || delta > bit_max_reg)
                                dropped = 1'b1;
                            else
                            begin
                                store_we  = in_store;
                                bits_next = bits_inc;
                                if (bits_inc == BITS_LIMIT)
                                    dropped = 1'b1;
                                else
                                begin
                                    want_rising_next = 1'b0;
                                    phase_next       = PH_SPACE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ACT_TICK:
                begin
                    if (armed_reg && s1_time_reg == deadline_reg)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_DONE;
                    end
                end
                ACT_READ:
                begin
                    read_go = phase_reg == PH_DONE;
                end
                default:
                begin
                end
            endcase

            // A dropped frame and a completed read both rearm the decoder.
            if (dropped || read_go)
            begin
                armed_next       = 1'b0;
                bits_next        = '0;
                phase_next       = PH_IDLE;
                want_rising_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rd_active_next = rd_active_reg;
        rd_idx_next    = rd_idx_reg;
        rd_last_next   = rd_last_reg;
        rd_total_next  = rd_total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (s1_fire)
        begin
            out_valid_next         = 1'b1;
            out_next.expect_rising = want_rising_next;
            out_next.frame_ready   = phase_next == PH_DONE;
            out_next.frame_dropped = dropped;
            out_next.read_valid    = read_go;
            out_next.data_byte     = '0;
            out_next.bit_total     = '0;
            out_next.last          = 1'b1;
            if (read_go && nbytes != 6'd0)
            begin
                out_next.data_byte = store_reg[0];
                out_next.bit_total = bits_reg;
                out_next.last      = nbytes == 6'd1;
                rd_active_next     = nbytes != 6'd1;
                rd_idx_next        = STORE_AW'(1);
                rd_last_next       = STORE_AW'(nbytes - 6'd1);
                rd_total_next      = bits_reg;
            end
        end
        else if (rd_fire)
        begin
            out_valid_next         = 1'b1;
            out_next.expect_rising = 1'b0;
            out_next.frame_ready   = 1'b0;
            out_next.frame_dropped = 1'b0;
            out_next.read_valid    = 1'b1;
            out_next.data_byte     = store_reg[rd_idx_reg];
            out_next.bit_total     = rd_total_reg;
            out_next.last          = rd_idx_reg == rd_last_reg;
            rd_idx_next            = rd_idx_reg + STORE_AW'(1);
            if (rd_idx_reg == rd_last_reg)
                rd_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_min_reg <= HEADER_MIN_RST;
            space_min_reg  <= SPACE_MIN_RST;
            space_max_reg  <= SPACE_MAX_RST;
            bit_min_reg    <= BIT_MIN_RST;
            bit_max_reg    <= BIT_MAX_RST;
            one_thresh_reg <= ONE_THRESH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER_MIN: header_min_reg <= cfg.data;
                REG_SPACE_MIN:  space_min_reg  <= cfg.data;
                REG_SPACE_MAX:  space_max_reg  <= cfg.data;
                REG_BIT_MIN:    bit_min_reg    <= cfg.data;
                REG_BIT_MAX:    bit_max_reg    <= cfg.data;
                REG_ONE_THRESH: one_thresh_reg <= cfg.data;
                REG_TIMEOUT:    timeout_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_IDLE;
            prev_reg        <= '0;
            bits_reg        <= '0;
            deadline_reg    <= '0;
            armed_reg       <= 1'b0;
            want_rising_reg <= 1'b0;
            rd_active_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            phase_reg       <= phase_next;
            prev_reg        <= prev_next;
            bits_reg        <= bits_next;
            deadline_reg    <= deadline_next;
            armed_reg       <= armed_next;
            want_rising_reg <= want_rising_next;
            rd_active_reg   <= rd_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                store_reg[i] <= '0;
        end
        else if (store_we)
            store_reg[wr_byte][wr_bit] <= store_bit;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_action_reg <= item.action;
            s1_time_reg   <= item.timestamp;
        end
        rd_idx_reg   <= rd_idx_next;
        rd_last_reg  <= rd_last_next;
        rd_total_reg <= rd_total_next;
        out_reg      <= out_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.expect_rising = out_reg.expect_rising;
    assign result.frame_ready   = out_reg.frame_ready;
    assign result.frame_dropped = out_reg.frame_dropped;
    assign result.read_valid    = out_reg.read_valid;
    assign result.data_byte     = out_reg.data_byte;
    assign result.bit_total     = out_reg.bit_total;
    assign result.last          = out_reg.last;

    // The deadline runs only between the header and the end of the frame.
    a_armed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (phase_reg == PH_SPACE || phase_reg == PH_PULSE))
        else $error("deadline armed outside the bit phases");

    // An overflowing frame must have been dropped before the count reaches the limit.
    a_bits_limit: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg != BITS_LIMIT)
        else $error("bit count reached the overflow limit");

    // While a frame read is still running, the pending result is a non-final data byte.
    a_read_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_active_reg |-> (out_valid_reg && out_reg.read_valid && !out_reg.last))
        else $error("frame read running without a pending data byte");

    // A read result always reports the rearmed decoder.
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.read_valid)
            |-> (!out_reg.frame_ready && !out_reg.expect_rising && !out_reg.frame_dropped))
        else $error("read result does not show a rearmed decoder");

    // The input register cannot advance while the read sequencer owns the result register.
    a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_active_reg && s1_valid_reg) |=> s1_valid_reg)
        else $error("queued transaction lost during a frame read");

endmodule
